// ===== src/btsd_pkg.sv =====
package btsd_pkg;

    // Design limits
    localparam int MAX_DIM    = 1024;
    localparam int COUNT_BITS = 20;

    // Field widths
    localparam int COLOR_BITS  = 8;
    localparam int COORD_BITS  = 10;
    localparam int FWIDTH_BITS = 11;
    localparam int WEIGHT_BITS = 9;
    localparam int LUMA_BITS   = 8;
    localparam int TOTAL_BITS  = 20;
    localparam int DEC_BITS    = 2;

    // Width used for centre-column arithmetic
    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int CMP_BITS = (DIM_BITS > FWIDTH_BITS) ? DIM_BITS : FWIDTH_BITS;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = FWIDTH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED_WEIGHT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLUE_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LUMA_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_FIRST      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LAST       = 3'd6;

    // Reset values of the configuration registers
    localparam logic [FWIDTH_BITS-1:0] RST_FRAME_WIDTH    = 11'd160;
    localparam logic [WEIGHT_BITS-1:0] RST_RED_WEIGHT     = 9'd77;
    localparam logic [WEIGHT_BITS-1:0] RST_GREEN_WEIGHT   = 9'd150;
    localparam logic [WEIGHT_BITS-1:0] RST_BLUE_WEIGHT    = 9'd29;
    localparam logic [LUMA_BITS-1:0]   RST_LUMA_THRESHOLD = 8'd230;
    localparam logic [COORD_BITS-1:0]  RST_ROW_FIRST      = 10'd25;
    localparam logic [COORD_BITS-1:0]  RST_ROW_LAST       = 10'd90;

    // Side decision codes
    localparam logic signed [DEC_BITS-1:0] SIDE_NONE  = 2'sd0;
    localparam logic signed [DEC_BITS-1:0] SIDE_LEFT  = -2'sd1;
    localparam logic signed [DEC_BITS-1:0] SIDE_RIGHT = 2'sd1;

    typedef struct packed {
        logic hot;
        logic left;
        logic right;
    } pix_class_t;

    typedef struct packed {
        logic [FWIDTH_BITS-1:0] frame_width;
        logic [WEIGHT_BITS-1:0] red_weight;
        logic [WEIGHT_BITS-1:0] green_weight;
        logic [WEIGHT_BITS-1:0] blue_weight;
        logic [LUMA_BITS-1:0]   luma_threshold;
        logic [COORD_BITS-1:0]  row_first;
        logic [COORD_BITS-1:0]  row_last;
    } cfg_t;

endpackage

// ===== src/btsd_pix_if.sv =====
interface btsd_pix_if;
    logic                                valid;
    logic                                ready;
    logic [btsd_pkg::COLOR_BITS-1:0]     red;
    logic [btsd_pkg::COLOR_BITS-1:0]     green;
    logic [btsd_pkg::COLOR_BITS-1:0]     blue;
    logic [btsd_pkg::COORD_BITS-1:0]     column;
    logic [btsd_pkg::COORD_BITS-1:0]     row;
    logic                                last_of_frame;

    modport source (output valid, red, green, blue, column, row, last_of_frame,
                    input ready);
    modport sink   (input valid, red, green, blue, column, row, last_of_frame,
                    output ready);
endinterface

// ===== src/btsd_res_if.sv =====
interface btsd_res_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  hot_pixel;
    logic                                  frame_done;
    logic signed [btsd_pkg::DEC_BITS-1:0]  side_decision;
    logic [btsd_pkg::TOTAL_BITS-1:0]       left_total;
    logic [btsd_pkg::TOTAL_BITS-1:0]       right_total;

    modport source (output valid, hot_pixel, frame_done, side_decision, left_total,
                    right_total, input ready);
    modport sink   (input valid, hot_pixel, frame_done, side_decision, left_total,
                    right_total, output ready);
endinterface

// ===== src/btsd_pixel_eval.sv =====
module btsd_pixel_eval (
    input  btsd_pkg::cfg_t                    cfg,
    input  logic [btsd_pkg::COLOR_BITS-1:0]   red,
    input  logic [btsd_pkg::COLOR_BITS-1:0]   green,
    input  logic [btsd_pkg::COLOR_BITS-1:0]   blue,
    input  logic [btsd_pkg::COORD_BITS-1:0]   column,
    input  logic [btsd_pkg::COORD_BITS-1:0]   row,
    output btsd_pkg::pix_class_t              pclass
);

    localparam int PROD_BITS = btsd_pkg::COLOR_BITS + btsd_pkg::WEIGHT_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int RAW_BITS  = SUM_BITS - 8;

    logic [PROD_BITS-1:0]              prod_r;
    logic [PROD_BITS-1:0]              prod_g;
    logic [PROD_BITS-1:0]              prod_b;
    logic [SUM_BITS-1:0]               luma_sum;
    logic [RAW_BITS-1:0]               luma_raw;
    logic [btsd_pkg::LUMA_BITS-1:0]    luma;
    logic [btsd_pkg::CMP_BITS-1:0]     width_ext;
    logic [btsd_pkg::CMP_BITS-1:0]     width_clamped;
    logic [btsd_pkg::CMP_BITS-1:0]     centre;
    logic [btsd_pkg::CMP_BITS-1:0]     column_ext;
    logic                              in_window;

    assign prod_r   = PROD_BITS'(red)   * PROD_BITS'(cfg.red_weight);
    assign prod_g   = PROD_BITS'(green) * PROD_BITS'(cfg.green_weight);
    assign prod_b   = PROD_BITS'(blue)  * PROD_BITS'(cfg.blue_weight);
    assign luma_sum = SUM_BITS'(prod_r) + SUM_BITS'(prod_g) + SUM_BITS'(prod_b);
    assign luma_raw = luma_sum[SUM_BITS-1:8];
    assign luma     = (luma_raw > RAW_BITS'(255)) ? '1 : luma_raw[btsd_pkg::LUMA_BITS-1:0];

    // centre column = min(width, MAX_DIM) / 2; the centre itself is neither side
    assign width_ext     = btsd_pkg::CMP_BITS'(cfg.frame_width);
    assign width_clamped = (width_ext > btsd_pkg::CMP_BITS'(btsd_pkg::MAX_DIM))
                           ? btsd_pkg::CMP_BITS'(btsd_pkg::MAX_DIM) : width_ext;
    assign centre        = width_clamped >> 1;
    assign column_ext    = btsd_pkg::CMP_BITS'(column);

    assign in_window = (row >= cfg.row_first) && (row <= cfg.row_last);

    assign pclass.hot   = (luma > cfg.luma_threshold) && in_window;
    assign pclass.left  = column_ext < centre;
    assign pclass.right = column_ext > centre;

endmodule

// ===== src/bright_target_side_detector_core.sv =====
// Channel  | Dir | Payload
// ---------+-----+-------------------------------------------------------------
// pix      | in  | red, green, blue, column, row, last_of_frame
// res      | out | hot_pixel, frame_done, side_decision, left_total, right_total
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle sustained while res is ready; res valid follows pix accept
// through the input register and then the result register.
// Reset clears the counts, the decision and the configuration to default values.
// A stalled result holds the pipeline; the input register still takes an item
// while it is empty, so ready only drops when both stages are full and res stalls.
module bright_target_side_detector_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [btsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [btsd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    btsd_pix_if.sink                              pix,
    btsd_res_if.source                            res
);

    btsd_pkg::cfg_t                          cfg_reg;

    logic                                    s1_valid_reg;
    logic [btsd_pkg::COLOR_BITS-1:0]         s1_red_reg;
    logic [btsd_pkg::COLOR_BITS-1:0]         s1_green_reg;
    logic [btsd_pkg::COLOR_BITS-1:0]         s1_blue_reg;
    logic [btsd_pkg::COORD_BITS-1:0]         s1_column_reg;
    logic [btsd_pkg::COORD_BITS-1:0]         s1_row_reg;
    logic                                    s1_last_reg;

    logic [btsd_pkg::COUNT_BITS-1:0]         left_count_reg;
    logic [btsd_pkg::COUNT_BITS-1:0]         right_count_reg;
    logic [btsd_pkg::COUNT_BITS-1:0]         left_count_next;
    logic [btsd_pkg::COUNT_BITS-1:0]         right_count_next;
    logic [btsd_pkg::COUNT_BITS-1:0]         left_total_next;
    logic [btsd_pkg::COUNT_BITS-1:0]         right_total_next;
    logic signed [btsd_pkg::DEC_BITS-1:0]    decision_reg;
    logic signed [btsd_pkg::DEC_BITS-1:0]    decision_next;

    logic                                    out_valid_reg;
    logic                                    out_hot_reg;
    logic                                    out_done_reg;
    logic signed [btsd_pkg::DEC_BITS-1:0]    out_dec_reg;
    logic [btsd_pkg::TOTAL_BITS-1:0]         out_left_reg;
    logic [btsd_pkg::TOTAL_BITS-1:0]         out_right_reg;

    btsd_pkg::pix_class_t                    pclass;
    logic                                    advance;
    logic                                    s1_fire;
    logic                                    pix_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= btsd_pkg::RST_FRAME_WIDTH;
            cfg_reg.red_weight     <= btsd_pkg::RST_RED_WEIGHT;
            cfg_reg.green_weight   <= btsd_pkg::RST_GREEN_WEIGHT;
            cfg_reg.blue_weight    <= btsd_pkg::RST_BLUE_WEIGHT;
            cfg_reg.luma_threshold <= btsd_pkg::RST_LUMA_THRESHOLD;
            cfg_reg.row_first      <= btsd_pkg::RST_ROW_FIRST;
            cfg_reg.row_last       <= btsd_pkg::RST_ROW_LAST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btsd_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data;
                btsd_pkg::REG_RED_WEIGHT:
                    cfg_reg.red_weight <= cfg_data[btsd_pkg::WEIGHT_BITS-1:0];
                btsd_pkg::REG_GREEN_WEIGHT:
                    cfg_reg.green_weight <= cfg_data[btsd_pkg::WEIGHT_BITS-1:0];
                btsd_pkg::REG_BLUE_WEIGHT:
                    cfg_reg.blue_weight <= cfg_data[btsd_pkg::WEIGHT_BITS-1:0];
                btsd_pkg::REG_LUMA_THRESHOLD:
                    cfg_reg.luma_threshold <= cfg_data[btsd_pkg::LUMA_BITS-1:0];
                btsd_pkg::REG_ROW_FIRST:
                    cfg_reg.row_first <= cfg_data[btsd_pkg::COORD_BITS-1:0];
                btsd_pkg::REG_ROW_LAST:
                    cfg_reg.row_last <= cfg_data[btsd_pkg::COORD_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    assign advance   = !out_valid_reg || res.ready;
    assign pix.ready = !s1_valid_reg || advance;
    assign pix_fire  = pix.valid && pix.ready;
    assign s1_fire   = s1_valid_reg && advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix.ready)
            s1_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_red_reg    <= pix.red;
            s1_green_reg  <= pix.green;
            s1_blue_reg   <= pix.blue;
            s1_column_reg <= pix.column;
            s1_row_reg    <= pix.row;
            s1_last_reg   <= pix.last_of_frame;
        end
    end

    btsd_pixel_eval u_eval (
        .cfg    (cfg_reg),
        .red    (s1_red_reg),
        .green  (s1_green_reg),
        .blue   (s1_blue_reg),
        .column (s1_column_reg),
        .row    (s1_row_reg),
        .pclass (pclass)
    );

    // saturating side counts, decision at frame end, clear after the last pixel
    always_comb
    begin
        left_total_next  = left_count_reg;
        right_total_next = right_count_reg;
        if (pclass.hot && pclass.left && (left_count_reg != '1))
            left_total_next = left_count_reg + 1'b1;
        if (pclass.hot && pclass.right && (right_count_reg != '1))
            right_total_next = right_count_reg + 1'b1;

        decision_next    = decision_reg;
        left_count_next  = left_total_next;
        right_count_next = right_total_next;
        if (s1_last_reg)
        begin
            if (left_total_next > right_total_next)
                decision_next = btsd_pkg::SIDE_LEFT;
            else if (right_total_next > left_total_next)
                decision_next = btsd_pkg::SIDE_RIGHT;
            left_count_next  = '0;
            right_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            decision_reg    <= btsd_pkg::SIDE_NONE;
        end
        else if (s1_fire)
        begin
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            decision_reg    <= decision_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_hot_reg   <= pclass.hot;
            out_done_reg  <= s1_last_reg;
            out_dec_reg   <= decision_next;
            out_left_reg  <= btsd_pkg::TOTAL_BITS'(left_total_next);
            out_right_reg <= btsd_pkg::TOTAL_BITS'(right_total_next);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.hot_pixel     = out_hot_reg;
    assign res.frame_done    = out_done_reg;
    assign res.side_decision = out_dec_reg;
    assign res.left_total    = out_left_reg;
    assign res.right_total   = out_right_reg;

endmodule
